// File: design/cltd_pkg.sv
// shared types, constants and the channel expansion table for the clut texture decoder
package cltd_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  typedef enum logic {
    REQ_PAL_WRITE = 1'b0,
    REQ_PIXEL     = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_NIBBLE = 2'd1,
    MODE_BYTE   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    K_WRITE  = 2'd0,
    K_DIRECT = 2'd1,
    K_NIBBLE = 2'd2,
    K_BYTE   = 2'd3
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  slot;
    logic [15:0] word;
  } q_item_t;

  // (c*255+15)/31 for every 5-bit channel value
  localparam logic [7:0] EXP5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return EXP5[c];
  endfunction

endpackage

// File: design/cltd_ram.sv
// generic single write port ram with registered read
module cltd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/cltd_front.sv
// request intake: colour mode register, request classification and the request queue
module cltd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            req_type,
  input  logic [7:0]      palette_slot,
  input  logic [15:0]     data_word,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata,
  output cltd_pkg::q_item_t head,
  output logic            head_valid,
  input  logic            pop
);
  import cltd_pkg::*;

  mode_t          mode;
  q_item_t        fifo [QDEPTH];
  q_item_t        item;
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DIRECT;
    end else if (cfg_we) begin
      mode <= mode_t'(cfg_wdata);
    end
  end

  always_comb begin
    item.slot = palette_slot;
    item.word = data_word;
    if (req_type == REQ_PAL_WRITE) begin
      item.kind = K_WRITE;
    end else begin
      case (mode)
        MODE_NIBBLE: item.kind = K_NIBBLE;
        MODE_BYTE:   item.kind = K_BYTE;
        default:     item.kind = K_DIRECT;
      endcase
    end
  end

  assign in_stall   = (count == (QAW+1)'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/cltd_back.sv
// request execution: palette writes, texel sequencing, palette read and colour expansion
module cltd_back (
  input  logic              clk,
  input  logic              rst,
  input  cltd_pkg::q_item_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [7:0]        alpha,
  output logic              last_texel
);
  import cltd_pkg::*;

  logic [1:0]        k;
  logic [1:0]        k_next;
  logic [7:0]        idx;
  logic              last;
  logic              issue;
  logic              can_issue;
  logic              out_free;
  logic              ram_we;
  logic              hit;
  logic [15:0]       rdata;
  logic              p1_valid;
  logic              p1_last;
  logic              p1_direct;
  logic              p1_hit;
  logic [15:0]       p1_word;
  logic [15:0]       colour;

  assign out_free  = !out_valid || !out_stall;
  assign can_issue = !p1_valid || out_free;

  always_comb begin
    idx    = '0;
    last   = 1'b1;
    issue  = 1'b0;
    ram_we = 1'b0;
    pop    = 1'b0;
    case (head.kind)
      K_WRITE: begin
        ram_we = head_valid && ({1'b0, head.slot} < 9'(PAL_ENTRIES));
        pop    = head_valid;
      end
      K_NIBBLE: begin
        idx   = {4'b0000, head.word[{k, 2'b00} +: 4]};
        last  = (k == 2'd3);
        issue = head_valid && can_issue;
        pop   = issue && last;
      end
      K_BYTE: begin
        idx   = k[0] ? head.word[15:8] : head.word[7:0];
        last  = k[0];
        issue = head_valid && can_issue;
        pop   = issue && last;
      end
      default: begin
        issue = head_valid && can_issue;
        pop   = issue;
      end
    endcase
    k_next = issue ? (last ? 2'd0 : k + 2'd1) : k;
  end

  assign hit = ({1'b0, idx} < 9'(PAL_ENTRIES));

  cltd_ram #(
    .WIDTH (16),
    .DEPTH (PAL_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.slot[PAL_AW-1:0]),
    .wdata (head.word),
    .re    (issue),
    .raddr (idx[PAL_AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else begin
      k <= k_next;
    end
  end

  // lookup stage, the ram read data lines up with it
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (can_issue) begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_last   <= last;
      p1_direct <= (head.kind == K_DIRECT);
      p1_hit    <= hit;
      p1_word   <= head.word;
    end
  end

  assign colour = p1_direct ? p1_word : (p1_hit ? rdata : 16'h0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_valid) begin
      red        <= expand5(colour[4:0]);
      green      <= expand5(colour[9:5]);
      blue       <= expand5(colour[14:10]);
      alpha      <= (colour == 16'h0000) ? 8'd0 : 8'd255;
      last_texel <= p1_last;
    end
  end

endmodule

// File: design/clut_texture_decoder.sv
// the first texel of a request passes through the request queue, the lookup stage and the output register
// throughput: one texel per cycle while the output is not stalled, set by the single palette read port of the back end
// a four-bit word yields four texels, an eight-bit word two, a direct word one; a palette write yields none
// a four-entry request queue lets intake run ahead while the output is stalled
// reset (rst, synchronous) empties the queue and pipeline and sets colour mode to direct
// palette contents are undefined after reset until written
module clut_texture_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  palette_slot,
  input  logic [15:0] data_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_texel
);
  import cltd_pkg::*;

  q_item_t head;
  logic    head_valid;
  logic    pop;

  cltd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .palette_slot (palette_slot),
    .data_word    (data_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  cltd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .last_texel (last_texel)
  );

endmodule

// File: design/cltd_checker.sv
// port level checks for the clut texture decoder and their bind
module cltd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha,
  input logic       last_texel
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({red, green, blue, alpha, last_texel}))
    else $error("stalled result changed");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("activity right after reset");

  // alpha is fully transparent or fully opaque
  a_alpha_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alpha == 8'd0) || (alpha == 8'd255))
    else $error("alpha level");

  // a transparent texel comes from a zero colour word
  a_clear_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && (alpha == 8'd0) |-> (red == 8'd0) && (green == 8'd0) && (blue == 8'd0))
    else $error("transparent texel not black");

endmodule

bind clut_texture_decoder cltd_checker u_cltd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .red        (red),
  .green      (green),
  .blue       (blue),
  .alpha      (alpha),
  .last_texel (last_texel)
);
